FILE: hw/rtl/fwtps_pkg.sv
// Shared constants and types for the four-wheel tooth-period tachometer.
// No dependencies; every other file refers to this package by scoped names.
package fwtps_pkg;

    // Wheels with edge tracking; at most SPEED_FIELDS of them are served
    localparam int WHEEL_COUNT  = 4;
    localparam int SPEED_FIELDS = 4;
    localparam int SERVED       = (WHEEL_COUNT < SPEED_FIELDS) ? WHEEL_COUNT : SPEED_FIELDS;

    localparam int DATA_W  = 32;
    localparam int LEVEL_W = 4;

    // Quotient bits retired per divider cycle
    localparam int RADIX_BITS = 4;
    localparam int DIV_CYCLES = DATA_W / RADIX_BITS;
    localparam int STEP_W     = $clog2(DIV_CYCLES);
    localparam int WHEEL_W    = $clog2(SPEED_FIELDS);

    // Queue between the edge tracker and the divider
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef logic [DATA_W-1:0]  word_t;
    typedef logic [LEVEL_W-1:0] levels_t;

    // One classified tick: levels and the tooth periods after this tick's edges
    typedef struct packed {
        levels_t                   levels;
        word_t [SPEED_FIELDS-1:0]  period;
    } tick_t;

    // Handshake between the queue and either side
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

FILE: hw/rtl/fwtps_front.sv
// Edge tracker: accepts sample ticks, detects rising edges, keeps edge times and periods.
// Depends on fwtps_pkg; pushes one tick_t per accepted sample into the queue.
module fwtps_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  fwtps_pkg::levels_t     wheel_levels,
    input  fwtps_pkg::word_t       sample_time,
    input  fwtps_pkg::fifo_status_t status,
    output logic                   push,
    output fwtps_pkg::tick_t       push_data
);

    logic             prev_level_reg  [fwtps_pkg::SERVED];
    fwtps_pkg::word_t last_edge_reg   [fwtps_pkg::SERVED];
    fwtps_pkg::word_t period_reg      [fwtps_pkg::SERVED];
    logic             prev_level_next [fwtps_pkg::SERVED];
    fwtps_pkg::word_t last_edge_next  [fwtps_pkg::SERVED];
    fwtps_pkg::word_t period_next     [fwtps_pkg::SERVED];
    logic             accept;

    assign sample_stall = status.full;
    assign accept       = sample_valid && !status.full;
    assign push         = accept;

    always_comb
    begin
        push_data.levels = wheel_levels;
        for (int k = 0; k < fwtps_pkg::SPEED_FIELDS; k++)
        begin
            push_data.period[k] = '0;
        end
        for (int w = 0; w < fwtps_pkg::SERVED; w++)
        begin
            prev_level_next[w] = wheel_levels[w];
            last_edge_next[w]  = last_edge_reg[w];
            period_next[w]     = period_reg[w];
            // rising edge: measure from the last edge, wrapping modulo 2^32
            if (!prev_level_reg[w] && wheel_levels[w])
            begin
                period_next[w]    = sample_time - last_edge_reg[w];
                last_edge_next[w] = sample_time;
            end
            push_data.period[w] = period_next[w];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < fwtps_pkg::SERVED; w++)
            begin
                prev_level_reg[w] <= 1'b0;
                last_edge_reg[w]  <= '0;
                period_reg[w]     <= '0;
            end
        end
        else if (accept)
        begin
            for (int w = 0; w < fwtps_pkg::SERVED; w++)
            begin
                prev_level_reg[w] <= prev_level_next[w];
                last_edge_reg[w]  <= last_edge_next[w];
                period_reg[w]     <= period_next[w];
            end
        end
    end

endmodule

FILE: hw/rtl/fwtps_fifo.sv
// Short queue of classified ticks between the edge tracker and the divider.
// Depends on fwtps_pkg for the entry type and depth.
module fwtps_fifo
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  fwtps_pkg::tick_t        push_data,
    input  logic                    pop,
    output fwtps_pkg::tick_t        pop_data,
    output fwtps_pkg::fifo_status_t status
);

    fwtps_pkg::tick_t                    mem [fwtps_pkg::FIFO_DEPTH];
    logic [fwtps_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg;
    logic [fwtps_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg;
    logic [fwtps_pkg::FIFO_CNT_W-1:0]    count_reg;
    logic                                do_push;
    logic                                do_pop;

    assign status.full  = (count_reg == fwtps_pkg::FIFO_CNT_W'(fwtps_pkg::FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == fwtps_pkg::FIFO_PTR_W'(fwtps_pkg::FIFO_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == fwtps_pkg::FIFO_PTR_W'(fwtps_pkg::FIFO_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/fwtps_back.sv
// Shared divider: works through the four wheels of one tick, RADIX_BITS quotient bits a cycle.
// Depends on fwtps_pkg; pops ticks from the queue and holds the finished result for output.
module fwtps_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  fwtps_pkg::word_t            distance,
    input  fwtps_pkg::fifo_status_t     status,
    input  fwtps_pkg::tick_t            pop_data,
    output logic                        pop,
    output logic                        speed_valid,
    input  logic                        speed_stall,
    output fwtps_pkg::levels_t          levels_out,
    output fwtps_pkg::word_t            speed_out [fwtps_pkg::SPEED_FIELDS]
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_PUBLISH
    } state_t;

    state_t                              state_reg;
    logic [fwtps_pkg::STEP_W-1:0]        step_reg;
    logic [fwtps_pkg::WHEEL_W-1:0]       wheel_reg;
    fwtps_pkg::levels_t                  levels_reg;
    fwtps_pkg::word_t                    period_reg [fwtps_pkg::SPEED_FIELDS];
    fwtps_pkg::word_t                    speed_reg  [fwtps_pkg::SPEED_FIELDS];
    fwtps_pkg::word_t                    rem_reg;
    fwtps_pkg::word_t                    quo_reg;
    logic                                out_valid_reg;
    fwtps_pkg::levels_t                  levels_out_reg;
    fwtps_pkg::word_t                    speed_out_reg [fwtps_pkg::SPEED_FIELDS];

    fwtps_pkg::word_t                    divisor;
    fwtps_pkg::word_t                    rem_next;
    fwtps_pkg::word_t                    quo_next;
    logic [fwtps_pkg::DATA_W:0]          trial;
    logic                                wheel_done;
    fwtps_pkg::word_t                    wheel_result;
    logic                                out_free;

    assign divisor  = period_reg[0];
    assign out_free = !out_valid_reg || !speed_stall;
    assign pop      = (state_reg == ST_IDLE) && !status.empty;

    // restoring division, RADIX_BITS dependent steps per cycle
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int i = 0; i < fwtps_pkg::RADIX_BITS; i++)
        begin
            trial    = {rem_next, quo_next[fwtps_pkg::DATA_W-1]};
            quo_next = {quo_next[fwtps_pkg::DATA_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                trial       = trial - {1'b0, divisor};
                quo_next[0] = 1'b1;
            end
            rem_next = trial[fwtps_pkg::DATA_W-1:0];
        end
    end

    // a zero period finishes at once with speed zero
    assign wheel_done   = (divisor == '0) ||
                          (step_reg == fwtps_pkg::STEP_W'(fwtps_pkg::DIV_CYCLES - 1));
    assign wheel_result = (divisor == '0) ? '0 : quo_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            wheel_reg      <= '0;
            out_valid_reg  <= 1'b0;
            levels_reg     <= '0;
            rem_reg        <= '0;
            quo_reg        <= '0;
            levels_out_reg <= '0;
            for (int k = 0; k < fwtps_pkg::SPEED_FIELDS; k++)
            begin
                period_reg[k]    <= '0;
                speed_reg[k]     <= '0;
                speed_out_reg[k] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && !speed_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!status.empty)
                    begin
                        levels_reg <= pop_data.levels;
                        for (int k = 0; k < fwtps_pkg::SPEED_FIELDS; k++)
                        begin
                            period_reg[k] <= pop_data.period[k];
                        end
                        rem_reg   <= '0;
                        quo_reg   <= distance;
                        step_reg  <= '0;
                        wheel_reg <= '0;
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    if (wheel_done)
                    begin
                        // advance to the next wheel: shift periods down, results in at the top
                        for (int k = 0; k < fwtps_pkg::SPEED_FIELDS - 1; k++)
                        begin
                            period_reg[k] <= period_reg[k+1];
                            speed_reg[k]  <= speed_reg[k+1];
                        end
                        period_reg[fwtps_pkg::SPEED_FIELDS-1] <= '0;
                        speed_reg[fwtps_pkg::SPEED_FIELDS-1]  <= wheel_result;
                        rem_reg  <= '0;
                        quo_reg  <= distance;
                        step_reg <= '0;
                        if (wheel_reg == fwtps_pkg::WHEEL_W'(fwtps_pkg::SPEED_FIELDS - 1))
                        begin
                            state_reg <= ST_PUBLISH;
                        end
                        else
                        begin
                            wheel_reg <= wheel_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        rem_reg  <= rem_next;
                        quo_reg  <= quo_next;
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_PUBLISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        levels_out_reg <= levels_reg;
                        for (int k = 0; k < fwtps_pkg::SPEED_FIELDS; k++)
                        begin
                            speed_out_reg[k] <= speed_reg[k];
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign speed_valid = out_valid_reg;
    assign levels_out  = levels_out_reg;
    assign speed_out   = speed_out_reg;

endmodule

FILE: hw/rtl/four_wheel_tooth_period_speed.sv
// Top level of the four-wheel tooth-period tachometer.
// Depends on fwtps_pkg, fwtps_front, fwtps_fifo and fwtps_back.
//
// Usage:
//   Sample channel (sample_valid / sample_stall): one request per timer tick,
//   carrying the four tooth-sensor levels and a 32-bit timestamp. A wheel
//   whose level rises gets a new tooth period, the timestamp minus its last
//   edge time (wrapping), and the timestamp becomes its new edge time.
//   Speed channel (speed_valid / speed_stall): one request per sample, the
//   sampled levels and per wheel floor(distance_per_tooth / period), zero
//   while a period is zero.
//   Configuration channel (cfg_valid / cfg_ready): writes distance_per_tooth,
//   unsigned Q16.16. cfg_ready is always high; write only while idle.
// Flow:
//   Edge tracking finishes in the accept cycle and the tick enters a
//   two-entry queue. One shared divider retires four quotient bits a cycle
//   for each wheel with a non-zero period and finishes a wheel with a zero
//   period at once. Each tick is loaded from the queue, divided wheel by
//   wheel and then published as one result.
// Reset clears edge state, periods, the register and the queue.
// While speed_stall is high the held result stays; the divider finishes the
// next tick and waits, and the queue keeps taking samples until it is full.
module four_wheel_tooth_period_speed
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  fwtps_pkg::word_t        distance_per_tooth,
    input  logic                    sample_valid,
    output logic                    sample_stall,
    input  fwtps_pkg::levels_t      wheel_levels,
    input  fwtps_pkg::word_t        sample_time,
    output logic                    speed_valid,
    input  logic                    speed_stall,
    output fwtps_pkg::levels_t      levels_out,
    output fwtps_pkg::word_t        speed_front_right,
    output fwtps_pkg::word_t        speed_front_left,
    output fwtps_pkg::word_t        speed_back_right,
    output fwtps_pkg::word_t        speed_back_left
);

    fwtps_pkg::word_t           distance_reg;
    fwtps_pkg::fifo_status_t    status;
    logic                       push;
    fwtps_pkg::tick_t           push_data;
    logic                       pop;
    fwtps_pkg::tick_t           pop_data;
    fwtps_pkg::word_t           speed_out [fwtps_pkg::SPEED_FIELDS];

    // configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            distance_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            distance_reg <= distance_per_tooth;
        end
    end

    fwtps_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .wheel_levels (wheel_levels),
        .sample_time  (sample_time),
        .status       (status),
        .push         (push),
        .push_data    (push_data)
    );

    fwtps_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (status)
    );

    fwtps_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .distance    (distance_reg),
        .status      (status),
        .pop_data    (pop_data),
        .pop         (pop),
        .speed_valid (speed_valid),
        .speed_stall (speed_stall),
        .levels_out  (levels_out),
        .speed_out   (speed_out)
    );

    // wheel order: front right, front left, back right, back left
    assign speed_front_right = speed_out[0];
    assign speed_front_left  = speed_out[1];
    assign speed_back_right  = speed_out[2];
    assign speed_back_left   = speed_out[3];

endmodule

FILE: tb/four_wheel_tooth_period_speed_test.sv
// Self-checking testbench for the four-wheel tooth-period tachometer: drives sample
// requests, predicts the four wheel speeds in step with them and checks every result.
// Depends on fwtps_pkg and four_wheel_tooth_period_speed.
module four_wheel_tooth_period_speed_test;
    timeunit 1ns;
    timeprecision 1ps;

    // One sample request as it goes on the wire
    typedef struct packed {
        fwtps_pkg::levels_t levels;
        fwtps_pkg::word_t   stamp;
    } tick_req_t;

    // One speed result: sampled levels plus speed per wheel, index 0 front right
    typedef struct packed {
        fwtps_pkg::levels_t                                 levels;
        fwtps_pkg::word_t [fwtps_pkg::SPEED_FIELDS-1:0]     speed;
    } speed_set_t;

    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LIMIT  = 10;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    fwtps_pkg::word_t       distance_per_tooth = '0;
    logic                   sample_valid = 1'b0;
    logic                   sample_stall;
    fwtps_pkg::levels_t     wheel_levels = '0;
    fwtps_pkg::word_t       sample_time = '0;
    logic                   speed_valid;
    logic                   speed_stall = 1'b0;
    fwtps_pkg::levels_t     levels_out;
    fwtps_pkg::word_t       speed_front_right;
    fwtps_pkg::word_t       speed_front_left;
    fwtps_pkg::word_t       speed_back_right;
    fwtps_pkg::word_t       speed_back_left;

    four_wheel_tooth_period_speed u_top
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .distance_per_tooth (distance_per_tooth),
        .sample_valid       (sample_valid),
        .sample_stall       (sample_stall),
        .wheel_levels       (wheel_levels),
        .sample_time        (sample_time),
        .speed_valid        (speed_valid),
        .speed_stall        (speed_stall),
        .levels_out         (levels_out),
        .speed_front_right  (speed_front_right),
        .speed_front_left   (speed_front_left),
        .speed_back_right   (speed_back_right),
        .speed_back_left    (speed_back_left)
    );

    // ------------------------------------------------------------------
    // Tachometer state as the block should hold it. Reset happens once, at
    // time zero, so the declaration values stand for the reset state.
    // ------------------------------------------------------------------
    logic [fwtps_pkg::WHEEL_COUNT-1:0] level_held = '0;
    fwtps_pkg::word_t   edge_stamp  [fwtps_pkg::WHEEL_COUNT] = '{default: '0};
    fwtps_pkg::word_t   tooth_ticks [fwtps_pkg::WHEEL_COUNT] = '{default: '0};
    fwtps_pkg::word_t   distance_now = '0;

    tick_req_t          pending_ticks [$];
    speed_set_t         expected_speeds [$];
    int                 ticks_queued = 0;
    int                 ticks_taken = 0;
    int                 mismatch_count = 0;

    // Driver and monitor pacing
    int                 send_gap = 0;
    int                 send_calm = 0;
    int                 hold_left = 0;
    int                 hold_calm = 0;
    logic               tick_taken;
    tick_req_t          next_tick;
    speed_set_t         wanted;

    fwtps_pkg::word_t [fwtps_pkg::SPEED_FIELDS-1:0] speed_seen;
    string speed_field [fwtps_pkg::SPEED_FIELDS] =
        '{"speed_front_right", "speed_front_left", "speed_back_right", "speed_back_left"};

    assign speed_seen = {speed_back_left, speed_back_right, speed_front_left, speed_front_right};

    // Advance the edge state by one tick and work out the speeds it reports.
    // Speeds use the periods that hold after this tick's edges.
    function automatic speed_set_t compute_speeds(input tick_req_t tick);
        speed_set_t result;
        int         w;
        result.levels = tick.levels;
        result.speed  = '0;
        for (w = 0; w < fwtps_pkg::SERVED; w++)
        begin
            // Rising edge: period is edge to edge, wrapping modulo 2^32
            if (!level_held[w] && tick.levels[w])
            begin
                tooth_ticks[w] = tick.stamp - edge_stamp[w];
                edge_stamp[w]  = tick.stamp;
            end
            level_held[w] = tick.levels[w];
            // No period yet, or an edge on the same stamp: speed is zero
            if (tooth_ticks[w] != '0)
                result.speed[w] = distance_now / tooth_ticks[w];
        end
        return result;
    endfunction

    // Length of the next idle run: mostly none or short, a few long, and now
    // and then a calm stretch with no idling at all.
    function automatic int idle_length(inout int calm);
        int roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 199);
        if (roll < 3)
        begin
            calm = $urandom_range(30, 120);
            return 0;
        end
        if (roll < 100)
            return 0;
        if (roll < 170)
            return $urandom_range(1, 3);
        if (roll < 192)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] seen);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t ns: %s wrong, expected %h, got %h", $time, field, want, seen);
    endtask

    task automatic queue_tick(input fwtps_pkg::levels_t levels, input fwtps_pkg::word_t stamp);
        pending_ticks.push_back('{levels: levels, stamp: stamp});
        ticks_queued++;
    endtask

    // Hold until every queued request has been taken and every result checked,
    // then let the divider settle before anything touches the register.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (ticks_taken != ticks_queued || expected_speeds.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write distance_per_tooth; call only right after a rising edge while idle
    task automatic write_distance(input fwtps_pkg::word_t value);
        cfg_valid          <= 1'b1;
        distance_per_tooth <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        distance_now = value;
        cfg_valid   <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Sample driver: take the next request from the pending queue, hold it
    // while the block stalls, and predict its result the moment it is taken.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
        end
        else
        begin
            tick_taken = sample_valid && !sample_stall;
            if (tick_taken)
            begin
                expected_speeds.push_back(compute_speeds({wheel_levels, sample_time}));
                ticks_taken++;
            end
            // A stalled request keeps its payload; only move on once it is gone
            if (!sample_valid || tick_taken)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    sample_valid <= 1'b0;
                end
                else if (pending_ticks.size() > 0)
                begin
                    next_tick     = pending_ticks.pop_front();
                    sample_valid <= 1'b1;
                    wheel_levels <= next_tick.levels;
                    sample_time  <= next_tick.stamp;
                    send_gap      = idle_length(send_calm);
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Speed monitor: check each result taken against the oldest prediction,
    // field by field, and stall the result channel at random.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_stall <= 1'b0;
        end
        else
        begin
            if (speed_valid && !speed_stall)
            begin
                if (expected_speeds.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t ns: speed result with none predicted, levels %h",
                                 $time, levels_out);
                end
                else
                begin
                    wanted = expected_speeds.pop_front();
                    if (wanted.levels !== levels_out)
                        note_mismatch("levels_out", 32'(wanted.levels), 32'(levels_out));
                    for (int w = 0; w < fwtps_pkg::SPEED_FIELDS; w++)
                    begin
                        if (wanted.speed[w] !== speed_seen[w])
                            note_mismatch(speed_field[w], wanted.speed[w], speed_seen[w]);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                speed_stall <= 1'b1;
            end
            else
            begin
                speed_stall <= 1'b0;
                hold_left    = idle_length(hold_calm);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: a directed run through the special cases, then random phases,
    // each under its own distance_per_tooth setting.
    // ------------------------------------------------------------------
    initial
    begin
        fwtps_pkg::word_t   phase_distance [7];
        fwtps_pkg::word_t   clock_now;
        fwtps_pkg::word_t   step;
        fwtps_pkg::levels_t levels_now;
        fwtps_pkg::levels_t flip;
        int                 roll;
        int                 phase;
        int                 n;
        int                 b;

        phase_distance = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h0000_8000,
                           32'h0400_0000, 32'h0, 32'h0};

        while (!rst_n)
            @(posedge clk);

        // Unit distance per tooth, so speeds read as 0x10000 / period
        write_distance(32'h0001_0000);
        queue_tick(4'h0, 32'h0000_0000);    // no edge yet: all speeds zero
        queue_tick(4'hF, 32'h0000_0064);    // first edge, measured from stamp zero
        queue_tick(4'h0, 32'h0000_0096);
        queue_tick(4'h1, 32'h0000_0064);    // edge on the last edge stamp: zero period
        queue_tick(4'h2, 32'hFFFF_FFF0);
        queue_tick(4'h0, 32'hFFFF_FFF8);
        queue_tick(4'h2, 32'h0000_0010);    // period spans the timestamp wrap
        queue_tick(4'h4, 32'h0000_0010);
        queue_tick(4'h0, 32'h0000_0011);
        queue_tick(4'h4, 32'h0000_0012);    // period of two
        queue_tick(4'h8, 32'hFFFF_FFFF);
        queue_tick(4'h0, 32'hFFFF_FFFF);
        queue_tick(4'h8, 32'h0000_0000);    // period of one across the wrap
        wait_idle();

        // Largest distance: a period of one gives the largest speed
        write_distance(32'hFFFF_FFFF);
        queue_tick(4'h0, 32'h0000_0005);
        queue_tick(4'hF, 32'h0000_0006);
        queue_tick(4'h0, 32'h0000_0007);
        queue_tick(4'hF, 32'h0000_0007);
        queue_tick(4'hF, 32'h0000_0009);    // levels held high: no new edges
        wait_idle();

        // Zero distance: every speed is zero whatever the periods
        write_distance(32'h0000_0000);
        queue_tick(4'h0, 32'h0000_000A);
        queue_tick(4'hF, 32'h0000_0014);
        wait_idle();

        // Random phases: mostly a steadily advancing clock with wheels toggling,
        // with some noise requests carrying arbitrary levels and stamps
        for (phase = 0; phase < 7; phase++)
        begin
            if (phase >= 5)
                phase_distance[phase] = $urandom;
            write_distance(phase_distance[phase]);
            clock_now  = (phase % 2) ? 32'hFFFF_0000 + $urandom_range(0, 16'hFFFF) : $urandom;
            levels_now = $urandom_range(0, 15);
            for (n = 0; n < 140; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 12)
                begin
                    levels_now = $urandom_range(0, 15);
                    queue_tick(levels_now, $urandom);
                end
                else
                begin
                    if (roll < 16)
                        step = '0;
                    else if (roll < 60)
                        step = $urandom_range(1, 16);
                    else if (roll < 85)
                        step = $urandom_range(17, 5000);
                    else if (roll < 97)
                        step = $urandom_range(5001, 32'h0010_0000);
                    else
                        step = $urandom;
                    clock_now = clock_now + step;
                    for (b = 0; b < fwtps_pkg::LEVEL_W; b++)
                        flip[b] = ($urandom_range(0, 99) < 45);
                    levels_now = levels_now ^ flip;
                    queue_tick(levels_now, clock_now);
                end
            end
            wait_idle();
        end

        if (mismatch_count == 0 && expected_speeds.size() == 0)
            $display("four_wheel_tooth_period_speed: match");
        else
            $display("four_wheel_tooth_period_speed: mismatch");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("four_wheel_tooth_period_speed: mismatch");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/fwtps_pkg.sv
hw/rtl/fwtps_front.sv
hw/rtl/fwtps_fifo.sv
hw/rtl/fwtps_back.sv
hw/rtl/four_wheel_tooth_period_speed.sv
tb/four_wheel_tooth_period_speed_test.sv
